@@ design/battery_sample_averager_defines.svh @@
// ----------------------------------------------------------------------------
// Battery sample averager assertion macros
// Assertion wrappers; ASSERT_OFF turns them into empty text.
// ----------------------------------------------------------------------------
`ifndef BATTERY_SAMPLE_AVERAGER_DEFINES_SVH
`define BATTERY_SAMPLE_AVERAGER_DEFINES_SVH

`ifndef ASSERT_OFF
// check under reset qualification
`define BSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check at every edge, reset included
`define BSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BSA_ASSERT(lbl, prop, msg)
`define BSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery sample averager package
// Widths, conversion constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int SAMPLES     = 10;
    localparam int ADC_W       = 10;
    localparam int MV_W        = 12;
    localparam int GOOD_W      = 7;
    localparam int TOTAL_W     = 18;
    localparam int CNT_W       = 7;
    localparam int DIV_STEPS   = TOTAL_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    // adc * 1000 / 1024, then * 36 / 10
    localparam int MV_SCALE    = 1000;
    localparam int MV_SHIFT    = 10;
    localparam int MV_MUL      = 36;
    localparam int PROD_W      = 16;
    // x / 10 == (x * 52429) >> 19, exact for x below 43699
    localparam int RECIP_10    = 52429;
    localparam int RECIP_SHIFT = 19;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef struct packed {
        logic load_in;
        logic conv1;
        logic conv2;
        logic conv3;
        logic accum;
        logic div_init;
        logic div_step;
        logic emit;
    } bsa_cmd_t;

    typedef struct packed {
        logic last_sample;
        logic div_done;
        logic out_free;
    } bsa_status_t;

endpackage

@@ design/battery_sample_averager.sv @@
// ----------------------------------------------------------------------------
// Battery sample averager
// Averages nonzero battery millivolt readings over a block of samples.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake         Payload
// s_       in   s_tvalid/tready   tuser: opcode; tdata: adc_sample
// m_       out  m_tvalid/tready   tuser: timed_out; tdata: average_mv, good_samples
//
// After a sample is accepted, s_tready stays low through the three
// conversion stages and the accumulate. The sample that completes a
// block, and a timeout, add division by the 18-step serial divider and
// hand-off. A pending result in the output register does not stop
// intake; only a second result waits for m_tready.
// Reset (aresetn low, synchronous) clears totals and control; no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_sample_averager
    import bsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
    input  logic                 s_tuser,   // [0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [11:0] average_mv, [18:12] good_samples
    output logic                 m_tuser    // [0] timed_out
);

    bsa_cmd_t    cmd;
    bsa_status_t status;

    bsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status_i (status),
        .cmd_o    (cmd)
    );

    bsa_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd_i    (cmd),
        .status_o (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ design/bsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Battery sample averager controller
// Sequences conversion, accumulation, division and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tuser,
    output logic        s_tready,
    input  bsa_status_t status_i,
    output bsa_cmd_t    cmd_o
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV1,
        ST_CONV2,
        ST_CONV3,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb begin
        cmd_o          = '0;
        cmd_o.load_in  = accept;
        cmd_o.conv1    = (state_reg == ST_CONV1);
        cmd_o.conv2    = (state_reg == ST_CONV2);
        cmd_o.conv3    = (state_reg == ST_CONV3);
        cmd_o.accum    = (state_reg == ST_ACCUM);
        cmd_o.div_init = (state_reg == ST_DIV_INIT);
        cmd_o.div_step = (state_reg == ST_DIV);
        cmd_o.emit     = (state_reg == ST_EMIT) && status_i.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ready_reg <= 1'b0;
                        state_reg <= (s_tuser == OP_TIMEOUT) ? ST_DIV_INIT : ST_CONV1;
                    end
                end
                ST_CONV1: state_reg <= ST_CONV2;
                ST_CONV2: state_reg <= ST_CONV3;
                ST_CONV3: state_reg <= ST_ACCUM;
                ST_ACCUM: begin
                    if (status_i.last_sample) begin
                        state_reg <= ST_DIV_INIT;
                    end else begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_DIV_INIT: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (status_i.div_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (status_i.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

@@ design/bsa_datapath.sv @@
// ----------------------------------------------------------------------------
// Battery sample averager datapath
// Millivolt conversion, running totals, serial divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "battery_sample_averager_defines.svh"

module bsa_datapath
    import bsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  bsa_cmd_t             cmd_i,
    output bsa_status_t          status_o,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    localparam int CONV_W  = ADC_W + MV_SHIFT;
    localparam int RECIP_W = 2 * PROD_W;
    localparam int REM_W   = CNT_W;

    logic                  op_reg;
    logic [ADC_W-1:0]      adc_reg;
    logic [ADC_W-1:0]      mv1_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [MV_W-1:0]       mv_reg;

    logic [TOTAL_W-1:0]    voltage_total_reg;
    logic [CNT_W-1:0]      sample_count_reg;
    logic [CNT_W-1:0]      failed_count_reg;

    logic [TOTAL_W-1:0]    div_quo_reg;
    logic [REM_W-1:0]      div_rem_reg;
    logic [CNT_W-1:0]      div_divisor_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [GOOD_W-1:0]     good_reg;

    logic                  m_tvalid_reg;
    logic [MV_W-1:0]       avg_out_reg;
    logic [GOOD_W-1:0]     good_out_reg;
    logic                  flag_out_reg;

    logic [CONV_W-1:0]     conv_prod;
    logic [RECIP_W-1:0]    recip_prod;
    logic [CNT_W-1:0]      good_next;
    logic [REM_W:0]        div_shift;
    logic [REM_W:0]        div_diff;
    logic                  div_bit;

    assign conv_prod  = CONV_W'(adc_reg) * CONV_W'(MV_SCALE);
    assign recip_prod = RECIP_W'(prod_reg) * RECIP_W'(RECIP_10);
    assign good_next  = sample_count_reg - failed_count_reg;

    assign div_shift  = {div_rem_reg, div_quo_reg[TOTAL_W-1]};
    assign div_diff   = div_shift - {1'b0, div_divisor_reg};
    assign div_bit    = (div_shift >= {1'b0, div_divisor_reg});

    assign status_o.last_sample = ({1'b0, sample_count_reg} + (CNT_W+1)'(1))
                                  >= (CNT_W+1)'(SAMPLES);
    assign status_o.div_done    = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status_o.out_free    = !m_tvalid_reg || m_tready;

    // conversion pipeline and input latch
    always_ff @(posedge aclk) begin
        if (cmd_i.load_in) begin
            op_reg  <= s_tuser;
            adc_reg <= s_tdata[ADC_W-1:0];
        end
        if (cmd_i.conv1) begin
            mv1_reg <= conv_prod[CONV_W-1:MV_SHIFT];
        end
        if (cmd_i.conv2) begin
            prod_reg <= PROD_W'(mv1_reg) * PROD_W'(MV_MUL);
        end
        if (cmd_i.conv3) begin
            mv_reg <= recip_prod[RECIP_SHIFT+MV_W-1:RECIP_SHIFT];
        end
    end

    // running totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voltage_total_reg <= '0;
            sample_count_reg  <= '0;
            failed_count_reg  <= '0;
        end else if (cmd_i.emit) begin
            voltage_total_reg <= '0;
            sample_count_reg  <= '0;
            failed_count_reg  <= '0;
        end else if (cmd_i.accum) begin
            if (mv_reg != '0) begin
                voltage_total_reg <= voltage_total_reg + TOTAL_W'(mv_reg);
            end else begin
                failed_count_reg <= failed_count_reg + CNT_W'(1);
            end
            sample_count_reg <= sample_count_reg + CNT_W'(1);
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd_i.div_init) begin
            div_quo_reg     <= voltage_total_reg;
            div_rem_reg     <= '0;
            div_cnt_reg     <= '0;
            good_reg        <= good_next;
            div_divisor_reg <= (good_next == '0) ? CNT_W'(SAMPLES) : good_next;
        end else if (cmd_i.div_step) begin
            div_quo_reg <= {div_quo_reg[TOTAL_W-2:0], div_bit};
            div_rem_reg <= div_bit ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.emit) begin
            avg_out_reg  <= div_quo_reg[MV_W-1:0];
            good_out_reg <= good_reg;
            flag_out_reg <= (op_reg == OP_TIMEOUT);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - MV_W - GOOD_W)'(0), good_out_reg, avg_out_reg};
    assign m_tuser  = flag_out_reg;

    `BSA_ASSERT(a_emit_slot_free, cmd_i.emit |-> (!m_tvalid_reg || m_tready), "emit over pending result")
    `BSA_ASSERT(a_clear_on_emit, cmd_i.emit |=> (sample_count_reg == '0 && voltage_total_reg == '0), "state not cleared after emit")
    `BSA_ASSERT(a_failed_le_count, failed_count_reg <= sample_count_reg, "failed count exceeds sample count")
    `BSA_ASSERT(a_divisor_nonzero, cmd_i.div_step |-> (div_divisor_reg != '0), "zero divisor in division")
    `BSA_ASSERT_ALWAYS(a_reset_idle_out, !aresetn |=> !m_tvalid_reg, "result valid after reset")

endmodule
